// File: hdl/smps_pkg.sv
// Shared types, opcodes and fp32 helpers for the sparse max-pooling scatter engine.
// No dependencies.
package smps_pkg;

  typedef enum logic [2:0] {
    OP_WR_POOL = 3'd0,
    OP_MAX     = 3'd1,
    OP_BWD     = 3'd2,
    OP_RD_POOL = 3'd3,
    OP_WR_GRAD = 3'd4,
    OP_RD_GRAD = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_ADD,
    ST_WB
  } state_e;

  localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [30:0] INF_MAG     = 31'h7F80_0000;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } fa_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] sum;
  } fa_rsp_t;

  function automatic logic f32_is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic f32_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (f32_is_nan(a) || f32_is_nan(b) || (a[30:0] == 31'd0 && b[30:0] == 31'd0)) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  function automatic logic f32_eq(input logic [31:0] a, input logic [31:0] b);
    return !f32_is_nan(a) && !f32_is_nan(b) &&
           ((a == b) || (a[30:0] == 31'd0 && b[30:0] == 31'd0));
  endfunction

endpackage

// File: hdl/sparse_maxpool_scatter_engine_core.sv
// Sparse max-pooling scatter engine: pooled and gradient stores in RAM, read-modify-write.
// Depends on smps_pkg, smps_ram, smps_fpadd.
//
//   channel | valid       | stall        | payload
//   in      | in_valid_i  | in_stall_o   | opcode_i, in_row_i, out_row_i, channel_i,
//           |             |              | feature_value_i, grad_value_i, batch_end_i
//   out     | out_valid_o | out_stall_i  | data_out_o, hit_o, batch_done_o
//
// Items go one at a time through accept, RAM read, then execute and write back.
// A matched backward accumulate waits in the add state for the 4-stage fp32 adder.
// Reset clears control state only; store contents are undefined until written.
// A new item is accepted while a result waits; it stalls in EXEC or WB until out frees.
module sparse_maxpool_scatter_engine_core #(
  parameter int unsigned ROWS     = 1024,
  parameter int unsigned CHANNELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [9:0]  in_row_i,
  input  logic [9:0]  out_row_i,
  input  logic [4:0]  channel_i,
  input  logic [31:0] feature_value_i,
  input  logic [31:0] grad_value_i,
  input  logic        batch_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] data_out_o,
  output logic        hit_o,
  output logic        batch_done_o
);

  localparam int unsigned Depth = ROWS * CHANNELS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  smps_pkg::state_e state_q, state_d;

  logic [2:0]    op_q;
  logic [AW-1:0] paddr_q, gaddr_q;
  logic          pok_q, gok_q, bend_q;
  logic [31:0]   fval_q, gval_q;

  logic          in_xfer, out_free, rd_en, p_we, g_we, out_load, bwd_match;
  logic [31:0]   pv, gv, g_wdata, res_data;
  logic          res_hit;
  logic          out_valid_q, hit_q, bd_q;
  logic [31:0]   data_q;

  smps_pkg::fa_req_t fa_req;
  smps_pkg::fa_rsp_t fa_rsp;

  assign in_stall_o = (state_q != smps_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign bwd_match  = (state_q == smps_pkg::ST_EXEC) && (op_q == smps_pkg::OP_BWD) &&
                      pok_q && gok_q && smps_pkg::f32_eq(pv, fval_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= opcode_i;
      paddr_q <= AW'(32'(out_row_i) * CHANNELS + 32'(channel_i));
      gaddr_q <= AW'(32'(in_row_i) * CHANNELS + 32'(channel_i));
      pok_q   <= (32'(out_row_i) < ROWS) && (32'(channel_i) < CHANNELS);
      gok_q   <= (32'(in_row_i) < ROWS) && (32'(channel_i) < CHANNELS);
      fval_q  <= feature_value_i;
      gval_q  <= grad_value_i;
      bend_q  <= batch_end_i;
    end
  end

  smps_ram #(.WIDTH(32), .DEPTH(Depth), .AW(AW)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (paddr_q),
    .wdata_i (fval_q),
    .re_i    (rd_en),
    .raddr_i (paddr_q),
    .rdata_o (pv)
  );

  smps_ram #(.WIDTH(32), .DEPTH(Depth), .AW(AW)) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (gaddr_q),
    .wdata_i (g_wdata),
    .re_i    (rd_en),
    .raddr_i (gaddr_q),
    .rdata_o (gv)
  );

  assign fa_req.start = bwd_match;
  assign fa_req.a     = gv;
  assign fa_req.b     = gval_q;

  smps_fpadd u_fpadd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fa_req),
    .rsp_o  (fa_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smps_pkg::ST_IDLE: if (in_xfer) state_d = smps_pkg::ST_READ;
      smps_pkg::ST_READ: state_d = smps_pkg::ST_EXEC;
      smps_pkg::ST_EXEC: begin
        if (bwd_match) begin
          state_d = smps_pkg::ST_ADD;
        end else if (out_free) begin
          state_d = smps_pkg::ST_IDLE;
        end
      end
      smps_pkg::ST_ADD:  if (fa_rsp.done) state_d = smps_pkg::ST_WB;
      smps_pkg::ST_WB:   if (out_free) state_d = smps_pkg::ST_IDLE;
      default:           state_d = smps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en    = (state_q == smps_pkg::ST_READ);
    p_we     = 1'b0;
    g_we     = 1'b0;
    g_wdata  = fval_q;
    out_load = 1'b0;
    res_data = 32'd0;
    res_hit  = 1'b0;
    unique case (state_q)
      smps_pkg::ST_EXEC: begin
        if (!bwd_match && out_free) begin
          out_load = 1'b1;
          case (op_q)
            smps_pkg::OP_WR_POOL: begin
              p_we     = pok_q;
              res_data = pok_q ? fval_q : 32'd0;
            end
            smps_pkg::OP_MAX: begin
              if (pok_q) begin
                if (smps_pkg::f32_lt(pv, fval_q)) begin
                  p_we     = 1'b1;
                  res_hit  = 1'b1;
                  res_data = fval_q;
                end else begin
                  res_data = pv;
                end
              end
            end
            smps_pkg::OP_BWD:     res_data = (pok_q && gok_q) ? gv : 32'd0;
            smps_pkg::OP_RD_POOL: res_data = pok_q ? pv : 32'd0;
            smps_pkg::OP_WR_GRAD: begin
              g_we     = gok_q;
              res_data = gok_q ? fval_q : 32'd0;
            end
            smps_pkg::OP_RD_GRAD: res_data = gok_q ? gv : 32'd0;
            default:              res_data = 32'd0;
          endcase
        end
      end
      smps_pkg::ST_WB: begin
        g_wdata = fa_rsp.sum;
        if (out_free) begin
          out_load = 1'b1;
          g_we     = 1'b1;
          res_hit  = 1'b1;
          res_data = fa_rsp.sum;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smps_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      data_q <= res_data;
      hit_q  <= res_hit;
      bd_q   <= bend_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = data_q;
  assign hit_o        = hit_q;
  assign batch_done_o = bd_q;

  a_adder_in_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fa_rsp.done |-> state_q == smps_pkg::ST_ADD)
    else $error("adder result outside add wait");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p_we && g_we))
    else $error("both stores written by one item");

  a_read_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> state_q == smps_pkg::ST_EXEC)
    else $error("read not followed by execute");

endmodule

// File: hdl/smps_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module smps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/smps_fpadd.sv
// Four-stage fp32 adder, round to nearest even, subnormals kept.
// Depends on smps_pkg.
module smps_fpadd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smps_pkg::fa_req_t req_i,
  output smps_pkg::fa_rsp_t rsp_o
);

  logic [3:0] v_q;

  // stage 1: specials, swap, align
  logic        s1_spec_d, s1_spec_q;
  logic [31:0] s1_sval_d, s1_sval_q;
  logic        s1_sign_d, s1_sign_q, s1_sub_d, s1_sub_q;
  logic [7:0]  s1_e_d, s1_e_q;
  logic [26:0] s1_mb_d, s1_mb_q, s1_ms_d, s1_ms_q;

  logic [31:0] big, sml;
  logic [7:0]  es, d;
  logic [26:0] ms_raw, ms_sh;

  always_comb begin
    s1_spec_d = 1'b1;
    s1_sval_d = 32'd0;
    if (smps_pkg::f32_is_nan(req_i.a)) begin
      s1_sval_d = req_i.a | smps_pkg::QNAN_BIT;
    end else if (smps_pkg::f32_is_nan(req_i.b)) begin
      s1_sval_d = req_i.b | smps_pkg::QNAN_BIT;
    end else if (req_i.a[30:0] == smps_pkg::INF_MAG && req_i.b[30:0] == smps_pkg::INF_MAG) begin
      s1_sval_d = (req_i.a[31] != req_i.b[31]) ? smps_pkg::DEFAULT_NAN : req_i.a;
    end else if (req_i.a[30:0] == smps_pkg::INF_MAG) begin
      s1_sval_d = req_i.a;
    end else if (req_i.b[30:0] == smps_pkg::INF_MAG) begin
      s1_sval_d = req_i.b;
    end else begin
      s1_spec_d = 1'b0;
    end
    if (req_i.a[30:0] < req_i.b[30:0]) begin
      big = req_i.b;
      sml = req_i.a;
    end else begin
      big = req_i.a;
      sml = req_i.b;
    end
    s1_e_d    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es        = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d         = s1_e_d - es;
    s1_mb_d   = {big[30:23] != 8'd0, big[22:0], 3'b000};
    ms_raw    = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      ms_sh = {26'd0, ms_raw != 27'd0};
    end else begin
      ms_sh    = ms_raw >> d;
      ms_sh[0] = ms_sh[0] | ((ms_raw & ~(27'h7FF_FFFF << d)) != 27'd0);
    end
    s1_ms_d   = ms_sh;
    s1_sign_d = big[31];
    s1_sub_d  = req_i.a[31] ^ req_i.b[31];
  end

  // stage 2: add or subtract magnitudes
  logic        s2_spec_q, s2_sign_q, s2_zero_q;
  logic [31:0] s2_sval_q;
  logic [7:0]  s2_e_q;
  logic [27:0] s2_sum_q, s2_sum_d;

  assign s2_sum_d = s1_sub_q ? ({1'b0, s1_mb_q} - {1'b0, s1_ms_q})
                             : ({1'b0, s1_mb_q} + {1'b0, s1_ms_q});

  // stage 3: normalize
  logic        s3_spec_q, s3_sign_q, s3_zero_q;
  logic [31:0] s3_sval_q;
  logic [8:0]  s3_e_q, s3_e_d, lim;
  logic [26:0] s3_n_q, s3_n_d;
  logic [4:0]  lz, sh;
  logic        found;

  always_comb begin
    lz    = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && s2_sum_q[i]) begin
        lz    = 5'(26 - i);
        found = 1'b1;
      end
    end
    lim = {1'b0, s2_e_q} - 9'd1;
    sh  = ({4'd0, lz} < lim) ? lz : lim[4:0];
    if (s2_sum_q[27]) begin
      s3_n_d    = s2_sum_q[27:1];
      s3_n_d[0] = s2_sum_q[1] | s2_sum_q[0];
      s3_e_d    = {1'b0, s2_e_q} + 9'd1;
    end else begin
      s3_n_d = s2_sum_q[26:0] << sh;
      s3_e_d = {1'b0, s2_e_q} - {4'd0, sh};
    end
  end

  // stage 4: round and pack
  logic [31:0] res_q, res_d;
  logic [30:0] base;
  logic        rnd;

  always_comb begin
    base = {(s3_n_q[26] ? s3_e_q[7:0] : 8'd0), s3_n_q[25:3]};
    rnd  = s3_n_q[2] & (s3_n_q[1] | s3_n_q[0] | s3_n_q[3]);
    if (s3_spec_q) begin
      res_d = s3_sval_q;
    end else if (s3_zero_q) begin
      res_d = {s3_sign_q, 31'd0};
    end else if (s3_e_q >= 9'd255) begin
      res_d = {s3_sign_q, smps_pkg::INF_MAG};
    end else begin
      res_d = {s3_sign_q, base + {30'd0, rnd}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 4'd0;
    end else begin
      v_q <= {v_q[2:0], req_i.start};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_spec_q <= s1_spec_d;
    s1_sval_q <= s1_sval_d;
    s1_sign_q <= s1_sign_d;
    s1_sub_q  <= s1_sub_d;
    s1_e_q    <= s1_e_d;
    s1_mb_q   <= s1_mb_d;
    s1_ms_q   <= s1_ms_d;
    s2_spec_q <= s1_spec_q;
    s2_sval_q <= s1_sval_q;
    s2_e_q    <= s1_e_q;
    s2_sum_q  <= s2_sum_d;
    s2_zero_q <= (s2_sum_d == 28'd0);
    s2_sign_q <= (s2_sum_d == 28'd0) ? (s1_sign_q & ~s1_sub_q) : s1_sign_q;
    s3_spec_q <= s2_spec_q;
    s3_sval_q <= s2_sval_q;
    s3_sign_q <= s2_sign_q;
    s3_zero_q <= s2_zero_q;
    s3_e_q    <= s3_e_d;
    s3_n_q    <= s3_n_d;
    res_q     <= res_d;
  end

  assign rsp_o.done = v_q[3];
  assign rsp_o.sum  = res_q;

endmodule
